/* src/acc_pkg.sv */
// Shared types, constants and helper functions for the alarm clock controller.
// Used by acc_core, acc_display and alarm_clock_controller. No dependencies.
package acc_pkg;

    localparam logic [15:0] FLASH_TICKS = 16'd40;
    localparam logic [15:0] ALARM_TICKS = 16'd1000;
    localparam logic [5:0]  HOURS_MAX   = 6'd23;
    localparam logic [5:0]  MINSEC_MAX  = 6'd59;
    localparam logic [3:0]  CODE_DASH   = 4'd10;
    localparam logic [3:0]  CODE_BLANK  = 4'd11;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_CLOCK_KEY = 3'd1,
        ACT_ALARM_KEY = 3'd2,
        ACT_UP        = 3'd3,
        ACT_DOWN      = 3'd4,
        ACT_SAMPLE    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        MODE_SHOW      = 3'd0,
        MODE_SET_CLK_H = 3'd1,
        MODE_SET_CLK_M = 3'd2,
        MODE_SET_CLK_S = 3'd3,
        MODE_SET_ALM_H = 3'd4,
        MODE_SET_ALM_M = 3'd5,
        MODE_SET_ALM_S = 3'd6
    } t_mode;

    // Snapshot of the controller state after one request has been applied.
    typedef struct packed {
        t_mode       mode;
        logic [4:0]  clk_h;
        logic [5:0]  clk_m;
        logic [5:0]  clk_s;
        logic [4:0]  alm_h;
        logic [5:0]  alm_m;
        logic [5:0]  alm_s;
        logic        light;
        logic        active;
        logic        wr;
    } t_acc_view;

    function automatic logic [5:0] step_up(input logic [5:0] v, input logic [5:0] mx);
        return (v >= mx) ? 6'd0 : v + 6'd1;
    endfunction

    function automatic logic [5:0] step_down(input logic [5:0] v, input logic [5:0] mx);
        return (v == 6'd0 || v > mx) ? mx : v - 6'd1;
    endfunction

    // Two digit codes for a value below 64; the tens digit comes from a
    // compare chain against multiples of ten.
    function automatic logic [7:0] pair_codes(input logic [5:0] v, input logic blank);
        logic [3:0] tens;
        logic [5:0] base;
        logic [5:0] units;
        if (v >= 6'd60) begin
            tens = 4'd6; base = 6'd60;
        end else if (v >= 6'd50) begin
            tens = 4'd5; base = 6'd50;
        end else if (v >= 6'd40) begin
            tens = 4'd4; base = 6'd40;
        end else if (v >= 6'd30) begin
            tens = 4'd3; base = 6'd30;
        end else if (v >= 6'd20) begin
            tens = 4'd2; base = 6'd20;
        end else if (v >= 6'd10) begin
            tens = 4'd1; base = 6'd10;
        end else begin
            tens = 4'd0; base = 6'd0;
        end
        units = v - base;
        if (blank) begin
            return {CODE_BLANK, CODE_BLANK};
        end
        return {tens, units[3:0]};
    endfunction

endpackage

/* src/acc_core.sv */
// State registers and update logic of the alarm clock controller.
// Depends on acc_pkg.
module acc_core
    import acc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [2:0] i_action,
    input  logic [4:0] i_hours,
    input  logic [5:0] i_minutes,
    input  logic [5:0] i_seconds,
    output t_acc_view  o_view
);

    t_mode       r_mode,   n_mode;
    logic [4:0]  r_clk_h,  n_clk_h;
    logic [5:0]  r_clk_m,  n_clk_m;
    logic [5:0]  r_clk_s,  n_clk_s;
    logic [4:0]  r_alm_h,  n_alm_h;
    logic [5:0]  r_alm_m,  n_alm_m;
    logic [5:0]  r_alm_s,  n_alm_s;
    logic        r_active, n_active;
    logic        r_phase,  n_phase;
    logic        r_light,  n_light;
    logic [15:0] r_flash,  n_flash;
    logic [15:0] r_dur,    n_dur;
    logic        n_wr;

    logic        up;
    logic [5:0]  clk_h_adj, clk_m_adj, clk_s_adj;
    logic [5:0]  alm_h_adj, alm_m_adj, alm_s_adj;
    logic [15:0] flash_inc, dur_inc;

    always_comb begin
        up        = (t_action'(i_action) == ACT_UP);
        clk_h_adj = up ? step_up({1'b0, r_clk_h}, HOURS_MAX)
                       : step_down({1'b0, r_clk_h}, HOURS_MAX);
        clk_m_adj = up ? step_up(r_clk_m, MINSEC_MAX) : step_down(r_clk_m, MINSEC_MAX);
        clk_s_adj = up ? step_up(r_clk_s, MINSEC_MAX) : step_down(r_clk_s, MINSEC_MAX);
        alm_h_adj = up ? step_up({1'b0, r_alm_h}, HOURS_MAX)
                       : step_down({1'b0, r_alm_h}, HOURS_MAX);
        alm_m_adj = up ? step_up(r_alm_m, MINSEC_MAX) : step_down(r_alm_m, MINSEC_MAX);
        alm_s_adj = up ? step_up(r_alm_s, MINSEC_MAX) : step_down(r_alm_s, MINSEC_MAX);
        flash_inc = r_flash + 16'd1;
        dur_inc   = r_dur + 16'd1;
    end

    always_comb begin
        n_mode   = r_mode;
        n_clk_h  = r_clk_h;
        n_clk_m  = r_clk_m;
        n_clk_s  = r_clk_s;
        n_alm_h  = r_alm_h;
        n_alm_m  = r_alm_m;
        n_alm_s  = r_alm_s;
        n_active = r_active;
        n_phase  = r_phase;
        n_light  = r_light;
        n_flash  = r_flash;
        n_dur    = r_dur;
        n_wr     = 1'b0;

        unique case (t_action'(i_action))
            ACT_TICK: begin
                n_flash = flash_inc;
                n_dur   = dur_inc;
                if (flash_inc == FLASH_TICKS && r_active) begin
                    n_flash = 16'd0;
                    n_phase = !r_phase;
                    n_light = !r_phase;
                end
                // The duration timer runs whether or not the alarm is sounding.
                if (dur_inc == ALARM_TICKS) begin
                    n_dur    = 16'd0;
                    n_active = 1'b0;
                    n_light  = 1'b0;
                end
            end
            ACT_CLOCK_KEY, ACT_ALARM_KEY, ACT_UP, ACT_DOWN: begin
                if (r_active) begin
                    // Any key silences the alarm and does nothing else.
                    n_active = 1'b0;
                    n_light  = 1'b0;
                end else if (t_action'(i_action) == ACT_CLOCK_KEY) begin
                    unique case (r_mode)
                        MODE_SHOW:      n_mode = MODE_SET_CLK_H;
                        MODE_SET_CLK_H: n_mode = MODE_SET_CLK_M;
                        MODE_SET_CLK_M: n_mode = MODE_SET_CLK_S;
                        MODE_SET_CLK_S: n_mode = MODE_SHOW;
                        default:        n_mode = r_mode;
                    endcase
                end else if (t_action'(i_action) == ACT_ALARM_KEY) begin
                    unique case (r_mode)
                        MODE_SHOW:      n_mode = MODE_SET_ALM_H;
                        MODE_SET_ALM_H: n_mode = MODE_SET_ALM_M;
                        MODE_SET_ALM_M: n_mode = MODE_SET_ALM_S;
                        MODE_SET_ALM_S: n_mode = MODE_SHOW;
                        default:        n_mode = r_mode;
                    endcase
                end else begin
                    unique case (r_mode)
                        MODE_SET_CLK_H: begin
                            n_clk_h = clk_h_adj[4:0];
                            n_wr    = 1'b1;
                        end
                        MODE_SET_CLK_M: begin
                            n_clk_m = clk_m_adj;
                            n_wr    = 1'b1;
                        end
                        MODE_SET_CLK_S: begin
                            n_clk_s = clk_s_adj;
                            n_wr    = 1'b1;
                        end
                        MODE_SET_ALM_H: n_alm_h = alm_h_adj[4:0];
                        MODE_SET_ALM_M: n_alm_m = alm_m_adj;
                        MODE_SET_ALM_S: n_alm_s = alm_s_adj;
                        default: ;
                    endcase
                end
            end
            ACT_SAMPLE: begin
                n_clk_h = i_hours;
                n_clk_m = i_minutes;
                n_clk_s = i_seconds;
                if (r_mode == MODE_SHOW && i_hours == r_alm_h
                        && i_minutes == r_alm_m && i_seconds == r_alm_s) begin
                    n_active = 1'b1;
                    n_flash  = 16'd0;
                    n_dur    = 16'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SHOW;
            r_clk_h  <= '0;
            r_clk_m  <= '0;
            r_clk_s  <= '0;
            r_alm_h  <= '0;
            r_alm_m  <= '0;
            r_alm_s  <= '0;
            r_active <= 1'b0;
            r_phase  <= 1'b0;
            r_light  <= 1'b0;
            r_flash  <= '0;
            r_dur    <= '0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_clk_h  <= n_clk_h;
            r_clk_m  <= n_clk_m;
            r_clk_s  <= n_clk_s;
            r_alm_h  <= n_alm_h;
            r_alm_m  <= n_alm_m;
            r_alm_s  <= n_alm_s;
            r_active <= n_active;
            r_phase  <= n_phase;
            r_light  <= n_light;
            r_flash  <= n_flash;
            r_dur    <= n_dur;
        end
    end

    always_comb begin
        o_view.mode   = n_mode;
        o_view.clk_h  = n_clk_h;
        o_view.clk_m  = n_clk_m;
        o_view.clk_s  = n_clk_s;
        o_view.alm_h  = n_alm_h;
        o_view.alm_m  = n_alm_m;
        o_view.alm_s  = n_alm_s;
        o_view.light  = n_light;
        o_view.active = n_active;
        o_view.wr     = n_wr;
    end

endmodule

/* src/acc_display.sv */
// Digit encoder: turns the updated state into eight display codes.
// Depends on acc_pkg.
module acc_display
    import acc_pkg::*;
(
    input  t_acc_view   i_view,
    output logic [31:0] o_digit_codes
);

    logic       odd;
    logic [5:0] h, m, s;
    logic       blank_h, blank_m, blank_s;

    always_comb begin
        odd     = i_view.clk_s[0];
        h       = {1'b0, i_view.clk_h};
        m       = i_view.clk_m;
        s       = i_view.clk_s;
        blank_h = 1'b0;
        blank_m = 1'b0;
        blank_s = 1'b0;
        // The field being edited blinks with the clock seconds.
        unique case (i_view.mode)
            MODE_SET_CLK_H: blank_h = odd;
            MODE_SET_CLK_M: blank_m = odd;
            MODE_SET_CLK_S: blank_s = odd;
            MODE_SET_ALM_H, MODE_SET_ALM_M, MODE_SET_ALM_S: begin
                h       = {1'b0, i_view.alm_h};
                m       = i_view.alm_m;
                s       = i_view.alm_s;
                blank_h = odd && (i_view.mode == MODE_SET_ALM_H);
                blank_m = odd && (i_view.mode == MODE_SET_ALM_M);
                blank_s = odd && (i_view.mode == MODE_SET_ALM_S);
            end
            default: ;
        endcase
        o_digit_codes = {pair_codes(h, blank_h), CODE_DASH,
                         pair_codes(m, blank_m), CODE_DASH,
                         pair_codes(s, blank_s)};
    end

endmodule

/* src/alarm_clock_controller.sv */
// Alarm clock controller top level: input register, update logic, result register.
// A request goes from the input register to the result register; while the output
// is stalled it waits in the input register.
// Throughput: one request per cycle without stalls; single registered state update.
// Reset (synchronous, active low) clears mode, times, alarm state, counters and valids.
// Depends on acc_pkg, acc_core and acc_display.
module alarm_clock_controller
    import acc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [4:0]  i_in_hours,
    input  logic [5:0]  i_in_minutes,
    input  logic [5:0]  i_in_seconds,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digit_codes,
    output logic        o_alarm_light,
    output logic        o_rtc_write,
    output logic [4:0]  o_write_hours,
    output logic [5:0]  o_write_minutes,
    output logic [5:0]  o_write_seconds
);

    logic        r_in_valid;
    logic [2:0]  r_action;
    logic [4:0]  r_hours;
    logic [5:0]  r_minutes;
    logic [5:0]  r_seconds;

    logic        r_out_valid;
    logic [31:0] r_digits;
    logic        r_light;
    logic        r_wr;
    logic [4:0]  r_wr_h;
    logic [5:0]  r_wr_m;
    logic [5:0]  r_wr_s;

    logic        out_free;
    logic        advance;
    logic        in_take;
    t_acc_view   view;
    logic [31:0] digits;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take || advance) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action  <= i_action;
            r_hours   <= i_in_hours;
            r_minutes <= i_in_minutes;
            r_seconds <= i_in_seconds;
        end
    end

    acc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_action  (r_action),
        .i_hours   (r_hours),
        .i_minutes (r_minutes),
        .i_seconds (r_seconds),
        .o_view    (view)
    );

    acc_display u_display (
        .i_view        (view),
        .o_digit_codes (digits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_digits <= digits;
            r_light  <= view.light;
            r_wr     <= view.wr;
            r_wr_h   <= view.wr ? view.clk_h : 5'd0;
            r_wr_m   <= view.wr ? view.clk_m : 6'd0;
            r_wr_s   <= view.wr ? view.clk_s : 6'd0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_digit_codes   = r_digits;
    assign o_alarm_light   = r_light;
    assign o_rtc_write     = r_wr;
    assign o_write_hours   = r_wr_h;
    assign o_write_minutes = r_wr_m;
    assign o_write_seconds = r_wr_s;

    // The input side only holds off while its register is full and blocked.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked request");

    // The light can only be lit while the alarm is sounding.
    a_light_needs_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && view.light) |-> view.active)
        else $error("alarm light on while alarm inactive");

    // Write-back values are zero whenever no write-back is requested.
    a_wr_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_wr) |-> (r_wr_h == 5'd0 && r_wr_m == 6'd0 && r_wr_s == 6'd0))
        else $error("write-back fields set without a write-back");

    // A request that advances out of the input register reaches the result register next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed request produced no result");

endmodule
